### src/lcr_pkg.sv
`default_nettype none

package lcr_pkg;

  // default sizing of the converter word and the averaging counter
  localparam int ADC_BITS_DEF   = 24;
  localparam int COUNT_BITS_DEF = 8;

  // fixed field widths on the ports
  localparam int IDX_W    = 5;
  localparam int AVG_W    = 24;
  localparam int NET_W    = 25;
  localparam int WEIGHT_W = 32;
  localparam int SCALE_W  = 32;
  localparam int SAMPLE_W = 8;
  localparam int GAIN_W   = 2;
  localparam int CMD_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 88;

  // rounding bias and shift for the 8 fraction bit weight
  localparam int WEIGHT_SHIFT = 16;

  // command codes carried with each tick
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MEASURE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TARE    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_RECIP  = 2'd2;

  // gain modes
  localparam logic [GAIN_W-1:0] GAIN_A128 = 2'd0;
  localparam logic [GAIN_W-1:0] GAIN_A64  = 2'd1;
  localparam logic [GAIN_W-1:0] GAIN_B32  = 2'd2;

  // register reset values
  localparam logic [SAMPLE_W-1:0] SAMPLE_RST = 8'd1;
  localparam logic [SCALE_W-1:0]  SCALE_RST  = 32'h0100_0000;

  // commands from the controller to the datapath
  typedef struct packed {
    logic tick_load;   // write a plain tick result to the output register
    logic sck;         // clock level of that tick
    logic busy;        // busy flag of that tick
    logic clr_word;    // clear the shift word
    logic clr_acc;     // clear the accumulator
    logic shift_en;    // shift the sampled data bit in
    logic acc_add;     // add the finished reading to the accumulator
    logic div_load;    // start the divider with accumulator plus reading
    logic div_step;    // one quotient bit
    logic net_calc;    // form average and net value
    logic is_tare;     // sequence in flight is a tare
    logic mul_go;      // multiply net by scale
    logic res_load;    // write the final result to the output register
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic out_free;    // output register can take a new item this cycle
  } dp_sts_t;

endpackage

`default_nettype wire

### src/lcr_cfg.sv
`default_nettype none

module lcr_cfg #(
  parameter int COUNT_BITS = 8
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [lcr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [lcr_pkg::SCALE_W-1:0]      cfg_data,
  output logic [1:0]                       gain_pulses,
  output logic [COUNT_BITS-1:0]            eff_count,
  output logic [lcr_pkg::SCALE_W-1:0]      scale_recip
);
  import lcr_pkg::*;

  logic [GAIN_W-1:0]   gain_mode_r;
  logic [SAMPLE_W-1:0] sample_count_r;
  logic [SCALE_W-1:0]  scale_recip_r;
  logic [COUNT_BITS-1:0] count_low;

  assign cfg_ready = 1'b1;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_mode_r    <= GAIN_A128;
      sample_count_r <= SAMPLE_RST;
      scale_recip_r  <= SCALE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GAIN_MODE:    gain_mode_r    <= cfg_data[GAIN_W-1:0];
        REG_SAMPLE_COUNT: sample_count_r <= cfg_data[SAMPLE_W-1:0];
        REG_SCALE_RECIP:  scale_recip_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // extra clock pulses after the data bits select the next gain
  always_comb begin
    unique case (gain_mode_r)
      GAIN_A64: gain_pulses = 2'd3;
      GAIN_B32: gain_pulses = 2'd2;
      default:  gain_pulses = 2'd1;
    endcase
  end

  // zero readings means one
  assign count_low = sample_count_r[COUNT_BITS-1:0];
  assign eff_count = (count_low == '0) ? COUNT_BITS'(1) : count_low;
  assign scale_recip = scale_recip_r;

endmodule

`default_nettype wire

### src/lcr_ctrl.sv
`default_nettype none

module lcr_ctrl #(
  parameter int ADC_BITS   = 24,
  parameter int COUNT_BITS = 8
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [lcr_pkg::CMD_W-1:0]    cmd,
  input  wire                          dout_level,
  input  wire  [1:0]                   gain_pulses,
  input  wire  [COUNT_BITS-1:0]        eff_count,
  input  wire  lcr_pkg::dp_sts_t       sts,
  output lcr_pkg::dp_cmd_t             dcmd
);
  import lcr_pkg::*;

  localparam int ACC_W = ADC_BITS + COUNT_BITS;
  localparam int DCNT_W = $clog2(ACC_W);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_WAIT = 9'b000000010,
    S_BHI  = 9'b000000100,
    S_BLO  = 9'b000001000,
    S_GHI  = 9'b000010000,
    S_GLO  = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_NET  = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0]      bit_r, bit_nxt;
  logic [IDX_W-1:0]      bit_inc;
  logic [COUNT_BITS-1:0] reads_r, reads_nxt, reads_inc;
  logic                  tare_r, tare_nxt;
  logic [DCNT_W-1:0]     dcnt_r, dcnt_nxt;
  logic                  mul_r, mul_nxt;
  logic                  tick_state;
  logic                  in_fire;

  // ticks are taken only in the link phases and while the output can take the item
  assign tick_state = (state_r == S_IDLE) || (state_r == S_WAIT) || (state_r == S_BHI) ||
                      (state_r == S_BLO) || (state_r == S_GHI) || (state_r == S_GLO);
  assign in_tready = tick_state && sts.out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign bit_inc   = bit_r + IDX_W'(1);
  assign reads_inc = reads_r + COUNT_BITS'(1);

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    bit_nxt   = bit_r;
    reads_nxt = reads_r;
    tare_nxt  = tare_r;
    dcnt_nxt  = dcnt_r;
    mul_nxt   = 1'b0;
    dcmd      = '0;
    dcmd.is_tare = tare_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          dcmd.tick_load = 1'b1;
          if (cmd == CMD_MEASURE || cmd == CMD_TARE) begin
            dcmd.busy     = 1'b1;
            dcmd.clr_word = 1'b1;
            dcmd.clr_acc  = 1'b1;
            tare_nxt  = (cmd == CMD_TARE);
            reads_nxt = '0;
            bit_nxt   = '0;
            state_nxt = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        if (in_fire) begin
          dcmd.tick_load = 1'b1;
          dcmd.busy      = 1'b1;
          if (!dout_level) begin
            dcmd.clr_word = 1'b1;
            bit_nxt   = '0;
            state_nxt = S_BHI;
          end
        end
      end
      S_BHI: begin
        if (in_fire) begin
          dcmd.tick_load = 1'b1;
          dcmd.busy      = 1'b1;
          dcmd.sck       = 1'b1;
          state_nxt      = S_BLO;
        end
      end
      S_BLO: begin
        if (in_fire) begin
          dcmd.tick_load = 1'b1;
          dcmd.busy      = 1'b1;
          dcmd.shift_en  = 1'b1;
          if (bit_inc >= IDX_W'(ADC_BITS)) begin
            bit_nxt   = '0;
            state_nxt = S_GHI;
          end else begin
            bit_nxt   = bit_inc;
            state_nxt = S_BHI;
          end
        end
      end
      S_GHI: begin
        if (in_fire) begin
          dcmd.tick_load = 1'b1;
          dcmd.busy      = 1'b1;
          dcmd.sck       = 1'b1;
          state_nxt      = S_GLO;
        end
      end
      S_GLO: begin
        if (in_fire) begin
          if (bit_inc < {{(IDX_W-2){1'b0}}, gain_pulses}) begin
            dcmd.tick_load = 1'b1;
            dcmd.busy      = 1'b1;
            bit_nxt        = bit_inc;
            state_nxt      = S_GHI;
          end else begin
            bit_nxt = '0;
            if (reads_inc >= eff_count || reads_inc == '0) begin
              // last read: result comes after divide and multiply
              dcmd.div_load = 1'b1;
              reads_nxt     = '0;
              dcnt_nxt      = '0;
              state_nxt     = S_DIV;
            end else begin
              dcmd.tick_load = 1'b1;
              dcmd.busy      = 1'b1;
              dcmd.acc_add   = 1'b1;
              reads_nxt      = reads_inc;
              state_nxt      = S_WAIT;
            end
          end
        end
      end
      S_DIV: begin
        dcmd.div_step = 1'b1;
        dcnt_nxt      = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(ACC_W - 1)) begin
          state_nxt = S_NET;
        end
      end
      S_NET: begin
        dcmd.net_calc = 1'b1;
        mul_nxt       = 1'b1;
        state_nxt     = S_FIN;
      end
      S_FIN: begin
        // product is registered in the cycle after the net value
        dcmd.mul_go = mul_r;
        if (!mul_r && sts.out_free) begin
          dcmd.res_load = 1'b1;
          tare_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bit_r   <= '0;
      reads_r <= '0;
      tare_r  <= 1'b0;
      dcnt_r  <= '0;
      mul_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bit_r   <= bit_nxt;
      reads_r <= reads_nxt;
      tare_r  <= tare_nxt;
      dcnt_r  <= dcnt_nxt;
      mul_r   <= mul_nxt;
    end
  end

endmodule

`default_nettype wire

### src/lcr_dp.sv
`default_nettype none

module lcr_dp #(
  parameter int ADC_BITS   = 24,
  parameter int COUNT_BITS = 8
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire  lcr_pkg::dp_cmd_t             dcmd,
  output lcr_pkg::dp_sts_t                   sts,
  input  wire                                dout_level,
  input  wire  [COUNT_BITS-1:0]              eff_count,
  input  wire  [lcr_pkg::SCALE_W-1:0]        scale_recip,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic                               sck_level,
  output logic                               busy_res,
  output logic                               result_valid,
  output logic                               was_tare,
  output logic [lcr_pkg::AVG_W-1:0]          raw_average,
  output logic signed [lcr_pkg::NET_W-1:0]   net_value,
  output logic signed [lcr_pkg::WEIGHT_W-1:0] weight_units
);
  import lcr_pkg::*;

  localparam int ACC_W  = ADC_BITS + COUNT_BITS;
  localparam int PROD_W = ADC_BITS + 1 + SCALE_W + 1;
  localparam int SH_W   = PROD_W - WEIGHT_SHIFT;

  logic [ADC_BITS-1:0]    word_r;
  logic [ACC_W-1:0]       acc_r;
  logic [ACC_W-1:0]       reading;
  logic [ACC_W-1:0]       acc_sum;
  logic [ADC_BITS-1:0]    tare_off_r;

  logic [ACC_W-1:0]       quo_r;
  logic [COUNT_BITS-1:0]  rem_r;
  logic [COUNT_BITS:0]    rem_sh;
  logic                   rem_ge;

  logic [ADC_BITS-1:0]         avg;
  logic [ADC_BITS-1:0]         avg_r;
  logic signed [ADC_BITS:0]    net_r;
  logic signed [ADC_BITS:0]    net_diff;
  logic signed [SCALE_W:0]     scale_s;
  logic signed [PROD_W-1:0]    prod_r;
  logic [PROD_W-1:0]           prod_rnd;
  logic [SH_W-1:0]             shifted;
  logic [WEIGHT_W-1:0]         weight_sat;
  logic                        hi_ones, hi_zeros;

  logic out_valid_r;
  logic out_free;

  assign out_free     = !out_valid_r || out_tready;
  assign sts.out_free = out_free;
  assign out_tvalid   = out_valid_r;

  // top bit flipped turns the two's complement reading into offset binary
  assign reading = ACC_W'({~word_r[ADC_BITS-1], word_r[ADC_BITS-2:0]});
  assign acc_sum = acc_r + reading;

  // serial shift word, accumulator and stored offset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r     <= '0;
      acc_r      <= '0;
      tare_off_r <= '0;
    end else begin
      if (dcmd.clr_word) begin
        word_r <= '0;
      end else if (dcmd.shift_en) begin
        word_r <= {word_r[ADC_BITS-2:0], dout_level};
      end
      if (dcmd.clr_acc || dcmd.div_load) begin
        acc_r <= '0;
      end else if (dcmd.acc_add) begin
        acc_r <= acc_sum;
      end
      if (dcmd.net_calc && dcmd.is_tare) begin
        tare_off_r <= avg;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {rem_r, quo_r[ACC_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, eff_count});

  always_ff @(posedge clk) begin
    if (dcmd.div_load) begin
      quo_r <= acc_sum;
      rem_r <= '0;
    end else if (dcmd.div_step) begin
      quo_r <= {quo_r[ACC_W-2:0], rem_ge};
      rem_r <= rem_ge ? COUNT_BITS'(rem_sh - {1'b0, eff_count}) : rem_sh[COUNT_BITS-1:0];
    end
  end

  // average and net value; a tare reports zero net
  assign avg      = quo_r[ADC_BITS-1:0];
  assign net_diff = $signed({1'b0, avg}) - $signed({1'b0, tare_off_r});
  assign scale_s  = $signed({1'b0, scale_recip});

  always_ff @(posedge clk) begin
    if (dcmd.net_calc) begin
      avg_r <= avg;
      net_r <= dcmd.is_tare ? '0 : net_diff;
    end
    if (dcmd.mul_go) begin
      prod_r <= net_r * scale_s;
    end
  end

  // round half up, drop 16 bits, saturate to 32 signed
  assign prod_rnd = prod_r + PROD_W'(1 << (WEIGHT_SHIFT - 1));
  assign shifted  = prod_rnd[PROD_W-1:WEIGHT_SHIFT];
  assign hi_ones  = &shifted[SH_W-1:WEIGHT_W-1];
  assign hi_zeros = ~|shifted[SH_W-1:WEIGHT_W-1];

  always_comb begin
    if (shifted[SH_W-1] && !hi_ones) begin
      weight_sat = {1'b1, {(WEIGHT_W-1){1'b0}}};
    end else if (!shifted[SH_W-1] && !hi_zeros) begin
      weight_sat = {1'b0, {(WEIGHT_W-1){1'b1}}};
    end else begin
      weight_sat = shifted[WEIGHT_W-1:0];
    end
  end

  // output item register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dcmd.tick_load || dcmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.tick_load) begin
      sck_level    <= dcmd.sck;
      busy_res     <= dcmd.busy;
      result_valid <= 1'b0;
      was_tare     <= 1'b0;
      raw_average  <= '0;
      net_value    <= '0;
      weight_units <= '0;
    end else if (dcmd.res_load) begin
      sck_level    <= 1'b0;
      busy_res     <= 1'b0;
      result_valid <= 1'b1;
      was_tare     <= dcmd.is_tare;
      raw_average  <= AVG_W'(avg_r);
      net_value    <= NET_W'(net_r);
      weight_units <= weight_sat;
    end
  end

endmodule

`default_nettype wire

### src/load_cell_adc_reader.sv
`default_nettype none

// Two-wire bridge converter reader. Each input item is one half period of the
// serial clock: tuser carries the command (tick, measure, tare) and tdata bit 0
// the sampled data pin; each item returns one output item with the clock level
// to drive for that half period and the busy flag. A measure or tare waits for
// the data pin to go low, clocks in ADC_BITS bits MSB first, adds 1, 3 or 2
// gain pulses by gain mode, and repeats for sample_count readings. The item
// that finishes the last reading returns the average, the net value against
// the stored offset and the scaled weight (8 fraction bits, saturated); a tare
// stores the average as the new offset instead. The finishing item passes
// through the restoring divider, which produces one quotient bit per cycle,
// then the net, multiply and output stages, and no new item is taken
// until the result is loaded. Configuration is taken at once on any cycle.
module load_cell_adc_reader #(
  parameter int ADC_BITS   = lcr_pkg::ADC_BITS_DEF,
  parameter int COUNT_BITS = lcr_pkg::COUNT_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // input channel
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire  [lcr_pkg::IN_DATA_W-1:0]      in_tdata,   // [0] dout_level, rest zero
  input  wire  [lcr_pkg::CMD_W-1:0]          in_tuser,   // [1:0] cmd
  // result channel
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // [0] sck_level, [1] busy_res, [2] result_valid, [26:3] raw_average,
  // [51:27] net_value, [83:52] weight_units, [87:84] zero
  output logic [lcr_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tuser,  // [0] was_tare
  // configuration
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [lcr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [lcr_pkg::SCALE_W-1:0]        cfg_data
);
  import lcr_pkg::*;

  logic [1:0]             gain_pulses;
  logic [COUNT_BITS-1:0]  eff_count;
  logic [SCALE_W-1:0]     scale_recip;
  dp_cmd_t                dcmd;
  dp_sts_t                sts;

  logic                         sck_level;
  logic                         busy_res;
  logic                         result_valid;
  logic                         was_tare;
  logic [AVG_W-1:0]             raw_average;
  logic signed [NET_W-1:0]      net_value;
  logic signed [WEIGHT_W-1:0]   weight_units;

  lcr_cfg #(
    .COUNT_BITS (COUNT_BITS)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .gain_pulses (gain_pulses),
    .eff_count   (eff_count),
    .scale_recip (scale_recip)
  );

  lcr_ctrl #(
    .ADC_BITS   (ADC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .cmd         (in_tuser),
    .dout_level  (in_tdata[0]),
    .gain_pulses (gain_pulses),
    .eff_count   (eff_count),
    .sts         (sts),
    .dcmd        (dcmd)
  );

  lcr_dp #(
    .ADC_BITS   (ADC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .dcmd         (dcmd),
    .sts          (sts),
    .dout_level   (in_tdata[0]),
    .eff_count    (eff_count),
    .scale_recip  (scale_recip),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .sck_level    (sck_level),
    .busy_res     (busy_res),
    .result_valid (result_valid),
    .was_tare     (was_tare),
    .raw_average  (raw_average),
    .net_value    (net_value),
    .weight_units (weight_units)
  );

  // pack the result fields
  assign out_tdata = {4'b0000, weight_units, net_value, raw_average,
                      result_valid, busy_res, sck_level};
  assign out_tuser = was_tare;

endmodule

`default_nettype wire
